// ===== hdl/pfsc_pkg.sv =====
`default_nettype none
package pfsc_pkg;

  localparam int SENSOR_W = 4;
  localparam int SEQ_W    = 32;
  localparam int CHK_W    = 32;
  localparam int KEY_W    = 16;
  localparam logic [KEY_W-1:0] KEY_RESET = 16'hABCD;

  // Word layouts, lowest bit first.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } pfsc_state_t;

  typedef struct packed {
    logic capture;   // latch input word and read the sensor entry
    logic execute;   // evaluate, write back and load the result word
  } pfsc_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/pfsc_ctrl.sv =====
`default_nettype none
module pfsc_ctrl
  import pfsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic      out_tready,
  output logic           out_tvalid,
  output pfsc_cmd_t      cmd
);

  pfsc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_tready     = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register is free or drains this cycle
        if (!out_valid_r || out_tready) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== hdl/pfsc_dpath.sv =====
`default_nettype none
module pfsc_dpath
  import pfsc_pkg::*;
#(
  parameter int NUM_SENSORS = 16,
  parameter int WINDOW      = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pfsc_cmd_t             cmd,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [KEY_W-1:0]      cfg_wr_data,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int BIT_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 2);

  logic [KEY_W-1:0] key_r;

  // Per-sensor state; seen bits are flops, the rest lives in memories.
  logic [NUM_SENSORS-1:0] seen_r;
  logic [SEQ_W-1:0]       front_mem [NUM_SENSORS];
  logic                   gap_mem   [NUM_SENSORS];
  logic [WINDOW-1:0]      bm_mem    [NUM_SENSORS];

  logic [SENSOR_W-1:0] sensor_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [CHK_W-1:0]    chk_r;
  logic [IDX_W-1:0]    idx_r;
  logic                in_range_r;
  logic [SEQ_W-1:0]    front_rd_r;
  logic                gap_rd_r;
  logic [WINDOW-1:0]   bm_rd_r;

  logic [SENSOR_W-1:0]      in_sensor;
  logic [IDX_W+SENSOR_W-1:0] in_sensor_wide;
  logic [IDX_W-1:0]         in_idx;
  logic                     in_range;

  assign in_sensor      = in_tdata[SENSOR_W-1:0];
  assign in_sensor_wide = {{IDX_W{1'b0}}, in_sensor};
  assign in_idx         = in_sensor_wide[IDX_W-1:0];
  assign in_range       = 32'(in_sensor) < 32'(NUM_SENSORS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= KEY_RESET;
    end else if (cfg_wr_en) begin
      key_r <= cfg_wr_data;
    end
  end

  // Capture the word and read the sensor entry.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sensor_r   <= in_sensor;
      seq_r      <= in_tdata[SENSOR_W +: SEQ_W];
      chk_r      <= in_tdata[SENSOR_W+SEQ_W +: CHK_W];
      idx_r      <= in_idx;
      in_range_r <= in_range;
      front_rd_r <= front_mem[in_idx];
      gap_rd_r   <= gap_mem[in_idx];
      bm_rd_r    <= bm_mem[in_idx];
    end
  end

  // Trailing-ones count of the ahead bitmap.
  logic [CNT_W-1:0] run_len;
  always_comb begin
    run_len = CNT_W'(WINDOW);
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (!bm_rd_r[i]) run_len = CNT_W'(i);
    end
  end

  logic [SEQ_W-1:0]  next_f, off;
  logic [WINDOW-1:0] bm_collapsed, bit_mask;
  logic              seen_cur;
  logic              dup, miss, beyond;
  logic [SEQ_W-1:0]  miss_seq;
  logic [SEQ_W-1:0]  f_nxt;
  logic              gap_nxt;
  logic [WINDOW-1:0] bm_nxt;
  logic              bad_chk;

  assign next_f       = front_rd_r + SEQ_W'(1);
  assign off          = seq_r - front_rd_r - SEQ_W'(2);
  assign bm_collapsed = (bm_rd_r >> run_len) >> 1;
  assign bit_mask     = WINDOW'(1) << off[BIT_W-1:0];
  assign seen_cur     = seen_r[idx_r];
  assign bad_chk      = chk_r != {seq_r[SEQ_W-1:KEY_W], seq_r[KEY_W-1:0] ^ key_r};

  always_comb begin
    dup      = 1'b0;
    miss     = 1'b0;
    beyond   = 1'b0;
    miss_seq = '0;
    f_nxt    = front_rd_r;
    gap_nxt  = gap_rd_r;
    bm_nxt   = bm_rd_r;
    if (in_range_r) begin
      if (!seen_cur) begin
        f_nxt   = seq_r;
        gap_nxt = 1'b0;
        bm_nxt  = '0;
      end else if (seq_r <= front_rd_r) begin
        dup = 1'b1;
      end else if (seq_r == next_f) begin
        f_nxt   = next_f + SEQ_W'(run_len);
        bm_nxt  = bm_collapsed;
        gap_nxt = 1'b0;
      end else begin
        if (!gap_rd_r) begin
          miss     = 1'b1;
          miss_seq = next_f;
        end
        gap_nxt = 1'b1;
        if (off >= SEQ_W'(WINDOW)) begin
          beyond = 1'b1;
        end else if ((bm_rd_r & bit_mask) != '0) begin
          dup = 1'b1;
        end else begin
          bm_nxt = bm_rd_r | bit_mask;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (cmd.execute && in_range_r) begin
      seen_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && in_range_r) begin
      front_mem[idx_r] <= f_nxt;
      gap_mem[idx_r]   <= gap_nxt;
      bm_mem[idx_r]    <= bm_nxt;
    end
  end

  logic [OUT_DATA_W-1:0] out_data_r;
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_data_r <= {beyond, miss_seq, miss, dup, bad_chk, seq_r, sensor_r};
    end
  end

  assign out_tdata = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/per_flow_sequence_checker.sv =====
// Per-flow packet sequence checker.
// Input stream (in_*): one word per packet carrying sensor index, sequence
// number and received checksum. Output stream (out_*): one result word per
// packet that echoes sensor and sequence and carries the flags chk_error,
// duplicate, missing (with missing_seq, the first missing number) and
// beyond_window. Packets with a sensor index at or above NUM_SENSORS get
// only the checksum check and leave all tracking state alone.
// Configuration: cfg_wr_en/cfg_wr_data load the 16-bit checksum key; write it
// only while no packet is in flight.
// Sequencing: a word is taken in the idle state and the per-sensor state
// entry is read from memory on that edge; in the evaluate state the update
// is written back and the result word is loaded. No new packet is taken
// before the last is through its state read-modify-write. The in-order path
// collapses the ahead bitmap with a priority encoder in the evaluate step.
// The result register parts the two sides: a new packet is taken while the
// last result still waits; if out_tready stays low the block holds in its
// evaluate step and in_tready stays low until the result register frees.
// Reset (rst_n, synchronous, active low) clears the per-sensor seen flags,
// which stands for clearing all per-sensor state, restores the key to 0xABCD
// and empties the output; the block takes words once reset is released.
`default_nettype none
module per_flow_sequence_checker
  import pfsc_pkg::*;
#(
  parameter int NUM_SENSORS = 16,
  parameter int WINDOW      = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [3:0] sensor, [35:4] seq, [67:36] checksum, [71:68] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [3:0] sensor_out, [35:4] seq_out, [36] chk_error, [37] duplicate,
  // [38] missing, [70:39] missing_seq, [71] beyond_window
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [KEY_W-1:0]      cfg_wr_data
);

  pfsc_cmd_t cmd;

  // Sequence the capture and evaluate steps, own the result valid.
  pfsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // State memories, flag logic, frontier advance and result register.
  pfsc_dpath #(
    .NUM_SENSORS (NUM_SENSORS),
    .WINDOW      (WINDOW)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

// ===== hdl/pfsc_checker.sv =====
`default_nettype none
module pfsc_checker
  import pfsc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [IN_DATA_W-1:0]  in_tdata,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // One packet at a time: no word taken on the edge after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted back to back");

  // With the output free, the result shows after the evaluate step and echoes seq.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |-> ##2
      (out_tvalid && out_tdata[35:4] == $past(in_tdata[35:4], 2)))
    else $error("result late or seq not echoed");

  // Beyond-window packets never count as duplicates.
  a_beyond_not_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[71] |-> !out_tdata[37])
    else $error("beyond_window with duplicate");

  // missing_seq is zero unless a gap is reported.
  a_miss_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[38] |-> out_tdata[70:39] == '0)
    else $error("missing_seq set without missing");

endmodule

bind per_flow_sequence_checker pfsc_checker u_pfsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
